FILE: rtl/zoom_coordinate_generator_defines.svh
// assertion macros used by the checker file
`ifndef ZOOM_COORDINATE_GENERATOR_DEFINES_SVH
`define ZOOM_COORDINATE_GENERATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define ZCG_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ZCG_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: rtl/zcg_pkg.sv
`default_nettype none

package zcg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COLUMNS   = 320;
  localparam int ROWS      = 180;

  localparam int LAST_IDX = (COLUMNS > ROWS) ? COLUMNS : ROWS;
  localparam int IDX_W    = $clog2(LAST_IDX + 1);

  localparam int TILE_LOG2    = 8;
  localparam int MIP_LEVELS   = 6;
  localparam int MIP_TOP_LOG2 = 15;

  localparam int ZD_W    = 17;
  localparam int OFS_W   = 17;
  localparam int STEP_W  = FRAC_BITS + 1;
  localparam int DIVD_W  = FRAC_BITS + TILE_LOG2 + 1;
  localparam int DCNT_W  = $clog2(DIVD_W);
  localparam int TSTEP_W = STEP_W + TILE_LOG2;
  localparam int ACC_W   = FRAC_BITS + 13;
  localparam int SH_W    = 4;

  localparam int MIP_W   = 3;
  localparam int TEXEL_W = 8;
  localparam int CTILE_W = 10;
  localparam int RBASE_W = 18;
  localparam int RTILE_W = 18;
  localparam int PREV_W  = 11;
  localparam int RTS_W   = 10;

  localparam int CTILE_LO = -256;
  localparam int CTILE_HI = 511;
  localparam int PREV_LO  = -1024;
  localparam int PREV_HI  = 1023;
  localparam int RB_IY_LO = -256;
  localparam int RB_IY_HI = 511;
  localparam int RBASE_LO = -65536;
  localparam int RBASE_HI = 131071;
  localparam int RTS_LIM  = 256;

  localparam logic [STEP_W-1:0] STEP_MAX = '1;
  localparam logic signed [ACC_W-1:0] ACC_MAX =
    ACC_W'((64'sd1 <<< (FRAC_BITS + 12)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX;

  typedef struct packed {
    logic latch;
    logic div_step;
    logic scale;
    logic origin;
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] hi;
    logic signed [ACC_W:0] lo;
    hi = (ACC_W + 1)'(ACC_MAX);
    lo = (ACC_W + 1)'(ACC_MIN);
    if (v > hi) begin
      return ACC_MAX;
    end else if (v < lo) begin
      return ACC_MIN;
    end else begin
      return v[ACC_W-1:0];
    end
  endfunction

  function automatic logic [MIP_W-1:0] mip_select(input logic [ZD_W-1:0] zd);
    logic [MIP_W-1:0] lvl;
    lvl = MIP_W'(MIP_LEVELS - 1);
    for (int i = MIP_LEVELS - 2; i >= 0; i--) begin
      if (zd > (ZD_W'(1) << (MIP_TOP_LOG2 - i))) begin
        lvl = MIP_W'(i);
      end
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/zcg_item_if.sv
`default_nettype none

interface zcg_item_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    restart;
  logic        [zcg_pkg::ZD_W-1:0]         zoom_div;
  logic signed [zcg_pkg::OFS_W-1:0]        offset_x;
  logic signed [zcg_pkg::OFS_W-1:0]        offset_y;

  modport source (output valid, restart, zoom_div, offset_x, offset_y, input ready);
  modport sink (input valid, restart, zoom_div, offset_x, offset_y, output ready);
endinterface

`default_nettype wire

FILE: rtl/zcg_result_if.sv
`default_nettype none

interface zcg_result_if;
  logic                                  valid;
  logic                                  ready;
  logic        [zcg_pkg::MIP_W-1:0]      mip_level;
  logic        [zcg_pkg::TEXEL_W-1:0]    col_texel;
  logic signed [zcg_pkg::CTILE_W-1:0]    col_tile;
  logic                                  col_valid;
  logic signed [zcg_pkg::RBASE_W-1:0]    row_base;
  logic signed [zcg_pkg::RTILE_W-1:0]    row_tile;
  logic                                  row_valid;
  logic                                  last;

  modport source (output valid, mip_level, col_texel, col_tile, col_valid, row_base,
                  row_tile, row_valid, last, input ready);
  modport sink (input valid, mip_level, col_texel, col_tile, col_valid, row_base,
                row_tile, row_valid, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/zcg_datapath.sv
`default_nettype none

module zcg_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  zcg_pkg::cmd_t                        cmd,
  output zcg_pkg::status_t                     status,
  input  logic        [zcg_pkg::ZD_W-1:0]      zoom_div,
  input  logic signed [zcg_pkg::OFS_W-1:0]     offset_x,
  input  logic signed [zcg_pkg::OFS_W-1:0]     offset_y,
  zcg_result_if.source                         result
);

  localparam int F    = zcg_pkg::FRAC_BITS;
  localparam int AW   = zcg_pkg::ACC_W;
  localparam int AW1  = zcg_pkg::ACC_W + 1;
  localparam int IW   = zcg_pkg::ACC_W - zcg_pkg::FRAC_BITS;
  localparam int SW2  = zcg_pkg::STEP_W + 2;
  localparam int ZW   = zcg_pkg::ZD_W;
  localparam int SHW  = zcg_pkg::SH_W;
  localparam int CTW  = zcg_pkg::CTILE_W;
  localparam int PW   = zcg_pkg::PREV_W;
  localparam int RBW  = zcg_pkg::RBASE_W;
  localparam int RTW  = zcg_pkg::RTILE_W;
  localparam int RSW  = zcg_pkg::RTS_W;
  localparam int TXW  = zcg_pkg::TEXEL_W;
  localparam int IXW  = zcg_pkg::IDX_W;

  localparam logic signed [AW-1:0] ONE_S   = AW'(1) << F;
  localparam logic signed [AW:0]   ORG_ONE = AW1'(64'sd1 <<< (F + zcg_pkg::TILE_LOG2));
  localparam logic signed [AW:0]   COLS_S  = AW1'(zcg_pkg::COLUMNS);

  localparam logic signed [IW-1:0] CT_LO = IW'(zcg_pkg::CTILE_LO);
  localparam logic signed [IW-1:0] CT_HI = IW'(zcg_pkg::CTILE_HI);
  localparam logic signed [IW-1:0] PR_LO = IW'(zcg_pkg::PREV_LO);
  localparam logic signed [IW-1:0] PR_HI = IW'(zcg_pkg::PREV_HI);
  localparam logic signed [IW-1:0] RI_LO = IW'(zcg_pkg::RB_IY_LO);
  localparam logic signed [IW-1:0] RI_HI = IW'(zcg_pkg::RB_IY_HI);
  localparam logic signed [IW-1:0] RS_HI = IW'(zcg_pkg::RTS_LIM);
  localparam logic signed [IW-1:0] RS_LO = -RS_HI;

  function automatic logic signed [AW-1:0] frac_scale(input logic signed [AW-1:0] v,
                                                      input logic [SHW-1:0] sh);
    logic [AW-1:0] mag;
    logic [AW-1:0] sc;
    mag = v[AW-1] ? -v : v;
    sc  = {{(AW - F){1'b0}}, mag[F-1:0]} << sh;
    return v[AW-1] ? -sc : sc;
  endfunction

  function automatic logic signed [IW-1:0] floor_of(input logic signed [AW-1:0] v);
    return v[AW-1:F];
  endfunction

  // latched restart fields
  logic        [ZW-1:0]               zd_lat;
  logic signed [zcg_pkg::OFS_W-1:0]   ox_lat;
  logic signed [zcg_pkg::OFS_W-1:0]   oy_lat;

  // divider
  logic [ZW-1:0]                 rem;
  logic [zcg_pkg::DIVD_W-1:0]    quot;
  logic [zcg_pkg::DCNT_W-1:0]    div_cnt;
  logic [ZW:0]                   trial;
  logic [ZW:0]                   diff;
  logic                          ge;

  // frame and walk state
  logic        [zcg_pkg::STEP_W-1:0]  step_size;
  logic        [zcg_pkg::TSTEP_W-1:0] tile_step;
  logic        [zcg_pkg::MIP_W-1:0]   level;
  logic signed [AW-1:0]               x_coord;
  logic signed [AW-1:0]               y_coord;
  logic signed [AW-1:0]               tile_x_acc;
  logic signed [AW-1:0]               tile_y_acc;
  logic        [TXW-1:0]              prev_col_texel;
  logic signed [PW-1:0]               prev_row_int;
  logic        [IXW-1:0]              step_index;

  logic [SHW-1:0]              tshift;
  logic signed [SW2-1:0]       sum_x;
  logic signed [SW2-1:0]       sum_y;
  logic signed [AW:0]          org_x;
  logic signed [AW:0]          org_y;

  logic                        cv;
  logic                        rv;
  logic                        is_last;
  logic        [TXW-1:0]       texel;
  logic signed [IW-1:0]        tx_int;
  logic signed [IW-1:0]        y_int;
  logic signed [IW-1:0]        ty_int;
  logic signed [AW-1:0]        tx_base;
  logic signed [AW-1:0]        ts_one;
  logic signed [AW-1:0]        ty_clamp;
  logic signed [AW-1:0]        ty_base;
  logic signed [CTW-1:0]       ctile;
  logic signed [PW-1:0]        iys;
  logic                        row_new;
  logic signed [RBW-1:0]       rbase;
  logic signed [RSW-1:0]       ty_sat;
  logic signed [RTW-1:0]       rtile;
  logic signed [AW-1:0]        x_next;
  logic signed [AW-1:0]        y_next;
  logic signed [AW-1:0]        tx_next;
  logic signed [AW-1:0]        ty_next;

  assign trial = {rem, div_cnt == '0};
  assign ge    = trial >= {1'b0, zd_lat};
  assign diff  = trial - {1'b0, zd_lat};

  assign status.div_last = div_cnt == zcg_pkg::DCNT_W'(zcg_pkg::DIVD_W - 1);
  assign status.out_free = !result.valid || result.ready;

  assign tshift = SHW'(zcg_pkg::TILE_LOG2) - SHW'(level);

  assign sum_x = $signed({2'b00, step_size}) + SW2'(ox_lat);
  assign sum_y = $signed({2'b00, step_size}) + SW2'(oy_lat);
  assign org_x = (ORG_ONE - AW1'(sum_x) * COLS_S) >>> 1;
  assign org_y = (ORG_ONE - AW1'(sum_y) * COLS_S) >>> 1;

  // column walk
  assign cv      = step_index < IXW'(zcg_pkg::COLUMNS);
  assign rv      = step_index < IXW'(zcg_pkg::ROWS);
  assign is_last = step_index == IXW'(zcg_pkg::COLUMNS - 1);
  assign texel   = x_coord[F+TXW-1:F];
  assign tx_base = (texel != prev_col_texel) ? '0 : tile_x_acc;
  assign tx_int  = floor_of(tx_base);
  assign x_next  = zcg_pkg::sat_acc(AW1'(x_coord) + AW1'($signed({1'b0, step_size})));
  assign tx_next = zcg_pkg::sat_acc(AW1'(tx_base) + AW1'($signed({1'b0, tile_step})));

  always_comb begin
    if (tx_int < CT_LO) begin
      ctile = CTW'(zcg_pkg::CTILE_LO);
    end else if (tx_int > CT_HI) begin
      ctile = CTW'(zcg_pkg::CTILE_HI);
    end else begin
      ctile = tx_int[CTW-1:0];
    end
  end

  // row walk
  assign y_int    = floor_of(y_coord);
  assign ts_one   = ONE_S <<< tshift;
  assign ty_clamp = (tile_y_acc > ts_one) ? ts_one : tile_y_acc;
  assign row_new  = prev_row_int < iys;
  assign ty_base  = row_new ? '0 : ty_clamp;
  assign ty_int   = floor_of(ty_base);
  assign rtile    = RTW'(ty_sat) <<< tshift;
  assign y_next   = zcg_pkg::sat_acc(AW1'(y_coord) + AW1'($signed({1'b0, step_size})));
  assign ty_next  = zcg_pkg::sat_acc(AW1'(ty_base) + AW1'($signed({1'b0, tile_step})));

  always_comb begin
    if (y_int < PR_LO) begin
      iys = PW'(zcg_pkg::PREV_LO);
    end else if (y_int > PR_HI) begin
      iys = PW'(zcg_pkg::PREV_HI);
    end else begin
      iys = y_int[PW-1:0];
    end
  end

  always_comb begin
    if (y_int < RI_LO) begin
      rbase = RBW'(zcg_pkg::RBASE_LO);
    end else if (y_int > RI_HI) begin
      rbase = RBW'(zcg_pkg::RBASE_HI);
    end else begin
      rbase = RBW'(y_int) <<< zcg_pkg::TILE_LOG2;
    end
  end

  always_comb begin
    if (ty_int < RS_LO) begin
      ty_sat = RSW'(RS_LO);
    end else if (ty_int > RS_HI) begin
      ty_sat = RSW'(RS_HI);
    end else begin
      ty_sat = ty_int[RSW-1:0];
    end
  end

  // restart fields and divider
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      zd_lat  <= zoom_div;
      ox_lat  <= offset_x;
      oy_lat  <= offset_y;
      rem     <= '0;
      quot    <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= ge ? diff[ZW-1:0] : trial[ZW-1:0];
      quot    <= {quot[zcg_pkg::DIVD_W-2:0], ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // frame and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size      <= '0;
      tile_step      <= '0;
      level          <= '0;
      x_coord        <= '0;
      y_coord        <= '0;
      tile_x_acc     <= '0;
      tile_y_acc     <= '0;
      prev_col_texel <= '0;
      prev_row_int   <= '0;
      step_index     <= '0;
    end else begin
      if (cmd.scale) begin
        step_size <= (quot > zcg_pkg::DIVD_W'(zcg_pkg::STEP_MAX)) ?
                     zcg_pkg::STEP_MAX : quot[zcg_pkg::STEP_W-1:0];
        level     <= zcg_pkg::mip_select(zd_lat);
      end
      if (cmd.origin) begin
        tile_step <= zcg_pkg::TSTEP_W'(step_size) << tshift;
        x_coord   <= zcg_pkg::sat_acc(org_x);
        y_coord   <= zcg_pkg::sat_acc(org_y);
      end
      if (cmd.load) begin
        tile_x_acc     <= frac_scale(x_coord, tshift);
        tile_y_acc     <= frac_scale(y_coord, tshift);
        prev_col_texel <= texel;
        prev_row_int   <= iys;
        step_index     <= '0;
      end
      if (cmd.step) begin
        if (cv) begin
          prev_col_texel <= texel;
          x_coord        <= x_next;
          tile_x_acc     <= tx_next;
        end
        if (rv) begin
          if (row_new) begin
            prev_row_int <= iys;
          end
          y_coord    <= y_next;
          tile_y_acc <= ty_next;
        end
        if (step_index < IXW'(zcg_pkg::LAST_IDX)) begin
          step_index <= step_index + 1'b1;
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.step) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      result.mip_level <= level;
      result.col_texel <= cv ? texel : '0;
      result.col_tile  <= cv ? ctile : '0;
      result.col_valid <= cv;
      result.row_base  <= rv ? rbase : '0;
      result.row_tile  <= rv ? rtile : '0;
      result.row_valid <= rv;
      result.last      <= is_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/zcg_ctrl.sv
`default_nettype none

module zcg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_restart,
  output logic              item_ready,
  input  zcg_pkg::status_t  status,
  output zcg_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV    = 6'b000010,
    S_SCALE  = 6'b000100,
    S_ORIGIN = 6'b001000,
    S_LOAD   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign item_ready = (state == S_IDLE) && status.out_free;
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (item_restart) begin
            cmd.latch  = 1'b1;
            state_next = S_DIV;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_ORIGIN;
      end
      S_ORIGIN: begin
        cmd.origin = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.step   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/zoom_coordinate_generator.sv
// Zoom texture-coordinate generator. A word with restart set latches zoom_div and the
// x/y offsets, derives the step (256 / zoom_div in Q.16), the mip level and the start
// coordinates, and returns the first column/row entry; every other word advances each
// axis still in range by one step and returns the next entry. A step word is accepted
// in the cycle its entry is loaded into the output register, so steps stream at one per
// clock while the sink keeps up and no restart is busy. A restart word passes through
// the restoring divider, which resolves one quotient bit per cycle, then the scale,
// origin, load and emit steps. Words sent before any restart run on the zero state.
`default_nettype none

module zoom_coordinate_generator (
  input  logic          clk,
  input  logic          rst,
  zcg_item_if.sink      item,
  zcg_result_if.source  result
);

  zcg_pkg::cmd_t    cmd;
  zcg_pkg::status_t status;

  zcg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_restart (item.restart),
    .item_ready   (item.ready),
    .status       (status),
    .cmd          (cmd)
  );

  zcg_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .zoom_div (item.zoom_div),
    .offset_x (item.offset_x),
    .offset_y (item.offset_y),
    .result   (result)
  );

endmodule

`default_nettype wire

FILE: rtl/zcg_checker.sv
`default_nettype none

`include "zoom_coordinate_generator_defines.svh"

module zcg_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 valid,
  input logic                                 ready,
  input logic        [zcg_pkg::TEXEL_W-1:0]   col_texel,
  input logic signed [zcg_pkg::CTILE_W-1:0]   col_tile,
  input logic                                 col_valid,
  input logic signed [zcg_pkg::RBASE_W-1:0]   row_base,
  input logic signed [zcg_pkg::RTILE_W-1:0]   row_tile,
  input logic                                 row_valid,
  input logic                                 last
);

  `ZCG_ASSERT_NEXT(a_hold, clk, rst, valid && !ready, valid, "word dropped while stalled")
  `ZCG_ASSERT_NOW(a_col_idle, clk, rst, valid && !col_valid, (col_texel == '0) && (col_tile == '0), "column fields set past the last column")
  `ZCG_ASSERT_NOW(a_row_idle, clk, rst, valid && !row_valid, (row_base == '0) && (row_tile == '0), "row fields set past the last row")
  `ZCG_ASSERT_NOW(a_last_col, clk, rst, valid && last, col_valid, "last outside the column range")

endmodule

bind zoom_coordinate_generator zcg_checker u_zcg_checker (
  .clk       (clk),
  .rst       (rst),
  .valid     (result.valid),
  .ready     (result.ready),
  .col_texel (result.col_texel),
  .col_tile  (result.col_tile),
  .col_valid (result.col_valid),
  .row_base  (result.row_base),
  .row_tile  (result.row_tile),
  .row_valid (result.row_valid),
  .last      (result.last)
);

`default_nettype wire
